>>> design/swmc_pkg.sv
`default_nettype none
package swmc_pkg;

  // Window depth; must be a power of two, at least 2 (the adder tree is a full binary tree).
  localparam int MAX_WINDOW  = 64;
  localparam int SAMPLE_BITS = 32;
  localparam int COST_BITS   = 38;
  localparam int WS_BITS     = 7;

  localparam int IDX_BITS    = $clog2(MAX_WINDOW);
  localparam int CNT_BITS    = IDX_BITS + 1;
  localparam int DIFF_BITS   = SAMPLE_BITS + 1;
  localparam int TREE_LEVELS = $clog2(MAX_WINDOW);
  localparam int LVL_BITS    = $clog2(TREE_LEVELS + 1);
  localparam int IN_BYTES    = (SAMPLE_BITS + 7) / 8;
  localparam int OUT_BYTES   = (COST_BITS + 7) / 8;

  // one window entry as handed between neighbor cells
  typedef struct packed {
    logic [SAMPLE_BITS-1:0] val;
    logic [IDX_BITS-1:0]    age;
  } entry_t;

  // broadcast from the sequencer to every cell
  typedef struct packed {
    logic                   load;
    logic                   diff_en;
    logic [SAMPLE_BITS-1:0] x;
    logic [CNT_BITS-1:0]    fill;
    logic                   full;
    logic [CNT_BITS-1:0]    fill_r;
    logic [IDX_BITS-1:0]    oldest;
    logic [IDX_BITS-1:0]    med_idx;
    logic [CNT_BITS-1:0]    k;
    logic [SAMPLE_BITS-1:0] med;
  } ctl_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MEDIAN,
    ST_DIFF,
    ST_SUM,
    ST_DONE
  } state_t;

endpackage
`default_nettype wire

>>> design/swmc_cell.sv
`default_nettype none
module swmc_cell (
  input  wire logic                             clk,
  input  wire logic [swmc_pkg::IDX_BITS-1:0]    idx,
  input  wire swmc_pkg::ctl_t                   ctl,
  input  wire logic [swmc_pkg::SAMPLE_BITS-1:0] evict_val,
  input  wire swmc_pkg::entry_t                 up_ent,
  input  wire swmc_pkg::entry_t                 dn_r_ent,
  input  wire logic                             dn_sh,
  output      swmc_pkg::entry_t                 ent,
  output      swmc_pkg::entry_t                 r_ent,
  output      logic                             sh,
  output      logic                             ev,
  output      logic [swmc_pkg::SAMPLE_BITS-1:0] med_val,
  output      logic [swmc_pkg::DIFF_BITS-1:0]   diff
);

  logic                           in_f;
  logic                           in_r;
  logic                           in_k;
  logic                           ge;
  swmc_pkg::entry_t               ent_next;
  logic [swmc_pkg::DIFF_BITS-1:0] d;
  logic [swmc_pkg::CNT_BITS-1:0]  idx_ext;

  assign idx_ext = {1'b0, idx};
  assign in_f    = idx_ext < ctl.fill;
  assign in_r    = idx_ext < ctl.fill_r;
  assign in_k    = idx_ext < ctl.k;

  // this entry is the oldest one and leaves the window
  assign ev = ctl.full && in_f && (ent.age == ctl.oldest);

  // at or above the evicted slot: pull the upper neighbor down
  // (the evicted entry is first among equal values, being the oldest)
  assign ge    = ctl.full && (!in_f || ($signed(ent.val) >= $signed(evict_val)));
  assign r_ent = ge ? up_ent : ent;

  // at or above the insert slot
  assign sh = !in_r || ($signed(r_ent.val) > $signed(ctl.x));

  always_comb begin
    if (!sh) begin
      ent_next.val = r_ent.val;
      ent_next.age = r_ent.age + swmc_pkg::IDX_BITS'(1);
    end else if (dn_sh) begin
      ent_next.val = dn_r_ent.val;
      ent_next.age = dn_r_ent.age + swmc_pkg::IDX_BITS'(1);
    end else begin
      ent_next.val = ctl.x;
      ent_next.age = '0;
    end
  end

  assign med_val = (idx == ctl.med_idx) ? ent.val : '0;

  assign d = $signed({ent.val[swmc_pkg::SAMPLE_BITS-1], ent.val})
           - $signed({ctl.med[swmc_pkg::SAMPLE_BITS-1], ctl.med});

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      ent <= ent_next;
    end
    if (ctl.diff_en) begin
      if (!in_k) begin
        diff <= '0;
      end else if (d[swmc_pkg::DIFF_BITS-1]) begin
        diff <= -d;
      end else begin
        diff <= d;
      end
    end
  end

endmodule
`default_nettype wire

>>> design/swmc_tree.sv
`default_nettype none
module swmc_tree (
  input  wire logic                           clk,
  input  wire logic [swmc_pkg::DIFF_BITS-1:0] leaf_in [swmc_pkg::MAX_WINDOW],
  output      logic [swmc_pkg::COST_BITS-1:0] root
);

  localparam int N = swmc_pkg::MAX_WINDOW;

  logic [swmc_pkg::COST_BITS-1:0] leaf [N];
  logic [swmc_pkg::COST_BITS-1:0] node [1:N-1];

  for (genvar i = 0; i < N; i++) begin : g_leaf
    assign leaf[i] = swmc_pkg::COST_BITS'(leaf_in[i]);
  end

  // heap order: node n sums children 2n and 2n+1, leaves sit past N-1
  for (genvar n = 1; n < N; n++) begin : g_node
    if (2 * n >= N) begin : g_bottom
      always_ff @(posedge clk) begin
        node[n] <= leaf[2*n-N] + leaf[2*n+1-N];
      end
    end else begin : g_inner
      always_ff @(posedge clk) begin
        node[n] <= node[2*n] + node[2*n+1];
      end
    end
  end

  assign root = node[1];

endmodule
`default_nettype wire

>>> design/sliding_window_median_cost.sv
`default_nettype none
// Channel    | Dir | Handshake                      | Payload
// s_axis     | in  | s_axis_tvalid / s_axis_tready  | tdata: sample; tuser: restart
// m_axis     | out | m_axis_tvalid / m_axis_tready  | tdata: cost (zero padded)
// cfg        | in  | cfg_valid / cfg_ready          | cfg_data: window_size
//
// A request that leaves the window short of K samples yields no cost; the sequencer stays idle.
// A request that yields a cost goes through chain update, median pick,
// per-cell deviation, 6 levels of the registered adder tree, output load.
// The adder tree depth (log2 of the window depth) sets the number of sum steps.
// Reset (rst, synchronous): window empty, window_size = 1, no result pending.
// A stalled m_axis holds the finished cost; the next request is still taken
// while it waits, and the sequencer only stalls when a second cost is ready.
module sliding_window_median_cost (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              s_axis_tvalid,
  output      logic                              s_axis_tready,
  input  wire logic [swmc_pkg::IN_BYTES*8-1:0]   s_axis_tdata,  // [31:0] sample
  input  wire logic                              s_axis_tuser,  // [0] restart
  output      logic                              m_axis_tvalid,
  input  wire logic                              m_axis_tready,
  output      logic [swmc_pkg::OUT_BYTES*8-1:0]  m_axis_tdata,  // [37:0] cost
  input  wire logic                              cfg_valid,
  output      logic                              cfg_ready,
  input  wire logic [swmc_pkg::WS_BITS-1:0]      cfg_data
);

  localparam int N = swmc_pkg::MAX_WINDOW;
  localparam int S = swmc_pkg::SAMPLE_BITS;

  swmc_pkg::state_t state, state_next;

  logic [swmc_pkg::WS_BITS-1:0]   window_size;
  logic [swmc_pkg::CNT_BITS-1:0]  fill;
  logic [swmc_pkg::LVL_BITS-1:0]  cnt;
  logic [swmc_pkg::LVL_BITS-1:0]  cnt_next;
  logic [S-1:0]                   med;
  logic [swmc_pkg::COST_BITS-1:0] cost;

  logic [swmc_pkg::CNT_BITS-1:0]  k_eff;
  logic [swmc_pkg::IDX_BITS-1:0]  km1;
  logic [swmc_pkg::CNT_BITS-1:0]  fill_in;
  logic [swmc_pkg::CNT_BITS-1:0]  fill_r;
  logic [swmc_pkg::CNT_BITS-1:0]  fill_new;
  logic                           full;
  logic                           has_result;
  logic                           in_fire;
  logic                           cfg_fire;
  logic                           med_load;
  logic                           diff_en;
  logic                           out_load;
  logic [S-1:0]                   evict_val;
  logic [S-1:0]                   med_sel;
  logic [swmc_pkg::COST_BITS-1:0] root;

  swmc_pkg::ctl_t                 ctl;
  swmc_pkg::entry_t               ent   [N];
  swmc_pkg::entry_t               r_ent [N];
  logic [N-1:0]                   sh;
  logic [N-1:0]                   ev;
  logic [S-1:0]                   med_val [N];
  logic [swmc_pkg::DIFF_BITS-1:0] diff  [N];

  // effective window: zero acts as 1, larger than the chain saturates
  always_comb begin
    if (window_size == '0) begin
      k_eff = swmc_pkg::CNT_BITS'(1);
    end else if (32'(window_size) > 32'(N)) begin
      k_eff = swmc_pkg::CNT_BITS'(N);
    end else begin
      k_eff = swmc_pkg::CNT_BITS'(window_size);
    end
  end
  assign km1 = swmc_pkg::IDX_BITS'(k_eff - swmc_pkg::CNT_BITS'(1));

  // fill bookkeeping for the request at the inputs
  assign fill_in    = (s_axis_tuser || (fill > k_eff)) ? '0 : fill;
  assign full       = (fill_in == k_eff);
  assign fill_r     = full ? (fill_in - swmc_pkg::CNT_BITS'(1)) : fill_in;
  assign fill_new   = fill_r + swmc_pkg::CNT_BITS'(1);
  assign has_result = (fill_new == k_eff);

  assign in_fire  = s_axis_tvalid && s_axis_tready;
  assign cfg_fire = cfg_valid && cfg_ready;

  // values of the entry being evicted and of the median (one-hot selects across the chain)
  always_comb begin
    evict_val = '0;
    med_sel   = '0;
    for (int i = 0; i < N; i++) begin
      evict_val = evict_val | (ev[i] ? ent[i].val : '0);
      med_sel   = med_sel | med_val[i];
    end
  end

  always_comb begin
    ctl.load    = in_fire;
    ctl.diff_en = diff_en;
    ctl.x       = s_axis_tdata[S-1:0];
    ctl.fill    = fill_in;
    ctl.full    = full;
    ctl.fill_r  = fill_r;
    ctl.oldest  = km1;
    ctl.med_idx = km1 >> 1;
    ctl.k       = k_eff;
    ctl.med     = med;
  end

  // sorted chain: cell 0 holds the smallest sample
  for (genvar i = 0; i < N; i++) begin : g_cell
    swmc_pkg::entry_t up_ent;
    swmc_pkg::entry_t dn_r_ent;
    logic             dn_sh;

    if (i == N - 1) begin : g_top_end
      assign up_ent = '0;
    end else begin : g_up
      assign up_ent = ent[i+1];
    end

    if (i == 0) begin : g_bot_end
      assign dn_r_ent = '0;
      assign dn_sh    = 1'b0;
    end else begin : g_dn
      assign dn_r_ent = r_ent[i-1];
      assign dn_sh    = sh[i-1];
    end

    swmc_cell u_cell (
      .clk       (clk),
      .idx       (swmc_pkg::IDX_BITS'(i)),
      .ctl       (ctl),
      .evict_val (evict_val),
      .up_ent    (up_ent),
      .dn_r_ent  (dn_r_ent),
      .dn_sh     (dn_sh),
      .ent       (ent[i]),
      .r_ent     (r_ent[i]),
      .sh        (sh[i]),
      .ev        (ev[i]),
      .med_val   (med_val[i]),
      .diff      (diff[i])
    );
  end

  swmc_tree u_tree (
    .clk     (clk),
    .leaf_in (diff),
    .root    (root)
  );

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= swmc_pkg::ST_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

  always_comb begin
    state_next    = state;
    cnt_next      = cnt;
    s_axis_tready = 1'b0;
    cfg_ready     = 1'b0;
    med_load      = 1'b0;
    diff_en       = 1'b0;
    out_load      = 1'b0;
    case (state)
      swmc_pkg::ST_IDLE: begin
        cfg_ready     = 1'b1;
        s_axis_tready = !cfg_valid;
        if (in_fire && has_result) begin
          state_next = swmc_pkg::ST_MEDIAN;
        end
      end
      swmc_pkg::ST_MEDIAN: begin
        med_load   = 1'b1;
        state_next = swmc_pkg::ST_DIFF;
      end
      swmc_pkg::ST_DIFF: begin
        diff_en    = 1'b1;
        cnt_next   = '0;
        state_next = swmc_pkg::ST_SUM;
      end
      swmc_pkg::ST_SUM: begin
        cnt_next = cnt + swmc_pkg::LVL_BITS'(1);
        if (cnt == swmc_pkg::LVL_BITS'(swmc_pkg::TREE_LEVELS - 1)) begin
          state_next = swmc_pkg::ST_DONE;
        end
      end
      swmc_pkg::ST_DONE: begin
        if (!m_axis_tvalid || m_axis_tready) begin
          out_load   = 1'b1;
          state_next = swmc_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = swmc_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      window_size   <= swmc_pkg::WS_BITS'(1);
      fill          <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (cfg_fire) begin
        window_size <= cfg_data;
        fill        <= '0;
      end else if (in_fire) begin
        fill <= fill_new;
      end
      m_axis_tvalid <= out_load || (m_axis_tvalid && !m_axis_tready);
    end
  end

  always_ff @(posedge clk) begin
    if (med_load) begin
      med <= med_sel;
    end
    if (out_load) begin
      cost <= root;
    end
  end

  assign m_axis_tdata = (swmc_pkg::OUT_BYTES*8)'(cost);

  // fill count never runs past the window
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= k_eff)
    else $error("fill count above window size");

  // a full window has exactly one oldest entry
  a_one_oldest: assert property (@(posedge clk) disable iff (rst)
    full |-> $onehot(ev))
    else $error("evict select not one-hot");

  // a finished cost never lands on one still waiting
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    out_load |-> (!m_axis_tvalid || m_axis_tready))
    else $error("output overwritten");

  // a new result only comes out of the done state
  a_out_src: assert property (@(posedge clk) disable iff (rst)
    $rose(m_axis_tvalid) |-> $past(state) == swmc_pkg::ST_DONE)
    else $error("result without sequencer");

endmodule
`default_nettype wire

>>> sim/tb_top.sv
`default_nettype none
module tb_top;

  localparam int CLK_HALF    = 5;
  localparam int RESET_CYC   = 9;
  localparam int SETTLE_CYC  = 24;      // margin beyond the time a cost takes
  localparam int CYCLE_LIMIT = 600000;
  localparam int PHASE_ITEMS = 120;
  localparam int NUM_PHASES  = 11;

  localparam int STYLE_MIXED   = 0;
  localparam int STYLE_EXTREME = 1;

  localparam logic [swmc_pkg::SAMPLE_BITS-1:0] S_MIN =
    {1'b1, {(swmc_pkg::SAMPLE_BITS-1){1'b0}}};
  localparam logic [swmc_pkg::SAMPLE_BITS-1:0] S_MAX =
    {1'b0, {(swmc_pkg::SAMPLE_BITS-1){1'b1}}};

  // Predicts the cost stream: own copy of the sorted window with ages, plus the
  // queue of costs still owed by the block.
  class median_cost_board;
    logic signed [swmc_pkg::SAMPLE_BITS-1:0] win_val[swmc_pkg::MAX_WINDOW];
    int unsigned                             win_age[swmc_pkg::MAX_WINDOW];
    int unsigned                             fill;
    logic [swmc_pkg::WS_BITS-1:0]            wsize;
    logic [swmc_pkg::COST_BITS-1:0]          costs_due[$];
    int                                      errors;

    function new();
      fill   = 0;
      wsize  = 1;
      errors = 0;
    endfunction

    // zero acts as 1, anything past the window depth saturates
    function int unsigned depth();
      if (wsize == 0) return 1;
      if (wsize > swmc_pkg::MAX_WINDOW) return swmc_pkg::MAX_WINDOW;
      return wsize;
    endfunction

    // a size write also empties the window
    function void set_window(logic [swmc_pkg::WS_BITS-1:0] v);
      wsize = v;
      fill  = 0;
    endfunction

    function int pending();
      return costs_due.size();
    endfunction

    function void note_sample(logic [swmc_pkg::SAMPLE_BITS-1:0] raw, logic rs);
      int unsigned k, i, pos;
      logic signed [swmc_pkg::SAMPLE_BITS-1:0] x;
      longint med, s;
      logic [63:0] sum;
      k = depth();
      x = raw;
      if (rs) fill = 0;
      if (fill > k) fill = 0;
      // full window: drop the oldest entry, close the gap
      if (fill == k) begin
        i = 0;
        while (i < fill && win_age[i] != k - 1) i++;
        if (i < fill) begin
          for (; i + 1 < fill; i++) begin
            win_val[i] = win_val[i+1];
            win_age[i] = win_age[i+1];
          end
          fill--;
        end else begin
          fill = 0;
        end
      end
      for (i = 0; i < fill; i++) win_age[i]++;
      // newest lands after all entries not above it (ties: older first)
      pos = 0;
      while (pos < fill && win_val[pos] <= x) pos++;
      for (i = fill; i > pos; i--) begin
        win_val[i] = win_val[i-1];
        win_age[i] = win_age[i-1];
      end
      win_val[pos] = x;
      win_age[pos] = 0;
      fill++;
      if (fill < k) return;
      med = longint'(win_val[(k + 1) / 2 - 1]);
      sum = 0;
      for (i = 0; i < k; i++) begin
        s = longint'(win_val[i]);
        if (s >= med) sum += 64'(s - med);
        else sum += 64'(med - s);
      end
      costs_due.insert(costs_due.size(), sum[swmc_pkg::COST_BITS-1:0]);
    endfunction

    function void check_cost(logic [swmc_pkg::OUT_BYTES*8-1:0] data);
      logic [swmc_pkg::COST_BITS-1:0] want, got;
      got = data[swmc_pkg::COST_BITS-1:0];
      if (costs_due.size() == 0) begin
        $error("cost: no request pending, expected none, actual %0d", got);
        errors++;
        return;
      end
      want = costs_due.pop_front();
      if (got !== want) begin
        $error("cost mismatch: expected %0d, actual %0d", want, got);
        errors++;
      end
    endfunction
  endclass

  logic                                clk = 1'b0;
  logic                                rst = 1'b1;
  logic                                s_axis_tvalid = 1'b0;
  logic                                s_axis_tready;
  logic [swmc_pkg::IN_BYTES*8-1:0]     s_axis_tdata = '0;   // [31:0] sample
  logic                                s_axis_tuser = 1'b0; // [0] restart
  logic                                m_axis_tvalid;
  logic                                m_axis_tready = 1'b0;
  logic [swmc_pkg::OUT_BYTES*8-1:0]    m_axis_tdata;        // [37:0] cost
  logic                                cfg_valid = 1'b0;
  logic                                cfg_ready;
  logic [swmc_pkg::WS_BITS-1:0]        cfg_data = '0;

  median_cost_board board;
  bit                idle_on = 1'b0;   // random gaps on both sides when set
  int                cycles = 0;
  int                stall_left = 0;

  sliding_window_median_cost dut (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data)
  );

  always #CLK_HALF clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    if (!idle_on) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(4, 30);
  endfunction

  // result side: check on every handshake, stall at random
  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) board.check_cost(m_axis_tdata);
    if (stall_left > 0) begin
      stall_left--;
      m_axis_tready <= 1'b0;
    end else begin
      stall_left = pick_gap();
      m_axis_tready <= (stall_left == 0);
    end
  end

  // tvalid stays up from one request to the next when no gap falls between them
  task automatic send_sample(logic [swmc_pkg::SAMPLE_BITS-1:0] smp, logic rs);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= smp;
    s_axis_tuser  <= rs;
    do @(posedge clk); while (!(s_axis_tvalid && s_axis_tready));
    board.note_sample(smp, rs);
  endtask

  task automatic stop_samples();
    s_axis_tvalid <= 1'b0;
  endtask

  // size writes only once every owed cost is out and the pipe has settled
  task automatic write_window(logic [swmc_pkg::WS_BITS-1:0] v);
    stop_samples();
    while (board.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYC) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!(cfg_valid && cfg_ready));
    cfg_valid <= 1'b0;
    board.set_window(v);
  endtask

  function automatic logic [swmc_pkg::SAMPLE_BITS-1:0] next_sample(int style);
    int r;
    if (style == STYLE_EXTREME) begin
      r = $urandom_range(0, 9);
      if (r < 9) return ($urandom_range(0, 1) != 0) ? S_MAX : S_MIN;
      return $urandom;
    end
    r = $urandom_range(0, 9);
    if (r < 6) return $urandom;
    if (r < 8) return swmc_pkg::SAMPLE_BITS'($signed($urandom_range(0, 6)) - 3);  // ties
    if (r < 9) return ($urandom_range(0, 1) != 0) ? S_MAX : S_MIN;
    return ($urandom_range(0, 1) != 0)
           ? S_MAX - swmc_pkg::SAMPLE_BITS'($urandom_range(0, 3))
           : S_MIN + swmc_pkg::SAMPLE_BITS'($urandom_range(0, 3));
  endfunction

  initial begin
    logic [swmc_pkg::WS_BITS-1:0] sizes[NUM_PHASES];
    int                           style, k;
    logic                         rs;
    board = new();
    sizes = '{7'd64, 7'd3, 7'd127, 7'd1, 7'd2, 7'd7, 7'd65, 7'd16, 7'd33, 7'd0, 7'd0};
    sizes[9]  = swmc_pkg::WS_BITS'($urandom_range(1, 12));
    sizes[10] = swmc_pkg::WS_BITS'($urandom_range(0, 127));

    repeat (RESET_CYC) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // size 1 out of reset: every request costs zero, extremes and a restart
    send_sample(S_MIN, 1'b0);
    send_sample(S_MAX, 1'b0);
    send_sample('0, 1'b1);
    send_sample('1, 1'b0);
    // size 0 behaves as 1
    write_window(7'd0);
    send_sample(32'd123, 1'b0);
    send_sample(-32'sd5, 1'b1);
    // size 2: widest neighbor difference, then a tie
    write_window(7'd2);
    send_sample(S_MAX, 1'b0);
    send_sample(S_MIN, 1'b0);
    send_sample(S_MIN, 1'b0);
    // size 3: equal values, restart mid-window, refill
    write_window(7'd3);
    send_sample(32'd5, 1'b0);
    send_sample(32'd5, 1'b0);
    send_sample(32'd9, 1'b1);
    send_sample(32'd5, 1'b0);
    send_sample(32'd5, 1'b0);
    send_sample(-32'sd2, 1'b0);
    send_sample(32'd5, 1'b0);

    // random phases across window sizes, idling on for most of them
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      write_window(sizes[ph]);
      idle_on = (ph % 3 != 1);
      style   = (sizes[ph] == 7'd127) ? STYLE_EXTREME : STYLE_MIXED;
      k       = board.depth();
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        rs = ($urandom_range(0, 99) < ((k <= 8) ? 5 : 1));
        send_sample(next_sample(style), rs);
      end
    end

    stop_samples();
    idle_on = 1'b0;
    while (board.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYC) @(posedge clk);
    if (board.errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
`default_nettype wire

>>> sim.f
design/swmc_pkg.sv
design/swmc_cell.sv
design/swmc_tree.sv
design/sliding_window_median_cost.sv
sim/tb_top.sv
